### hdl/ffse_pkg.sv
// Shared constants and types for the FASTA/FASTQ sequence extractor.
`timescale 1ns / 1ps

package ffse_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_GT   = 8'd62;
    localparam logic [7:0] CH_AT   = 8'd64;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_N    = 8'd78;

    typedef enum logic [4:0] {
        PH_NORMAL  = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PLUS    = 5'b00100,
        PH_QUAL    = 5'b01000,
        PH_SWALLOW = 5'b10000
    } t_phase;

endpackage

### hdl/fasta_fastq_sequence_extractor.sv
// Top level of the FASTA/FASTQ sequence extractor.
`timescale 1ns / 1ps

// Takes one file byte per word and returns only the sequence letters. Line
// breaks are dropped, a header line gives one 'N' separator, and in FASTQ
// mode (i_cfg_data = 1) the quality section after a '+' line is skipped by
// counting the letters of the record. A word with i_end_of_input set gives a
// done word with byte 0. Throughput is one input word per cycle while
// o_in_stall is low: the parser state and letter counter are registered
// from the accepted word, and each result is registered in a two-entry
// output buffer (output register plus skid register) that keeps input
// accepted while a result waits; o_in_stall rises only when both entries
// hold words. Write format mode only while the block is idle.
module fasta_fastq_sequence_extractor
    import ffse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_stream_done
);

    logic                  r_fastq;
    t_phase                r_phase,     n_phase;
    logic                  r_prev_nl,   n_prev_nl;
    logic [COUNT_BITS-1:0] r_count,     n_count;

    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte,  n_out_byte;
    logic                  r_out_done,  n_out_done;
    logic                  r_skid_valid, n_skid_valid;
    logic [7:0]            r_skid_byte, n_skid_byte;
    logic                  r_skid_done, n_skid_done;

    logic       in_acc;
    logic       out_take;
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_done;
    logic       is_nl;
    logic       count_nz;
    logic       count_max;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    assign is_nl     = (i_in_byte == CH_NL);
    assign count_nz  = (r_count != '0);
    assign count_max = (r_count == {COUNT_BITS{1'b1}});

    // parser step
    always_comb begin
        n_phase   = r_phase;
        n_prev_nl = r_prev_nl;
        n_count   = r_count;
        res_valid = 1'b0;
        res_byte  = i_in_byte;
        res_done  = 1'b0;
        if (in_acc) begin
            if (i_end_of_input) begin
                n_phase   = PH_NORMAL;
                res_valid = 1'b1;
                res_byte  = '0;
                res_done  = 1'b1;
            end else begin
                n_prev_nl = is_nl;
                case (r_phase)
                    PH_HEADER: begin
                        if (is_nl) n_phase = PH_NORMAL;
                    end
                    PH_PLUS: begin
                        if (is_nl) n_phase = count_nz ? PH_QUAL : PH_NORMAL;
                    end
                    PH_QUAL: begin
                        if (!is_nl) begin
                            if (count_nz) n_count = r_count - COUNT_BITS'(1);
                            if (r_count <= COUNT_BITS'(1)) n_phase = PH_SWALLOW;
                        end
                    end
                    PH_SWALLOW: begin
                        n_phase = PH_NORMAL;
                    end
                    default: begin
                        n_phase = PH_NORMAL;
                        if (!is_nl) begin
                            if (!r_fastq) begin
                                res_valid = 1'b1;
                                if (i_in_byte == CH_GT && r_prev_nl) begin
                                    n_phase  = PH_HEADER;
                                    res_byte = CH_N;
                                end
                            end else if (i_in_byte == CH_AT) begin
                                res_valid = 1'b1;
                                if (r_prev_nl) begin
                                    n_phase  = PH_HEADER;
                                    n_count  = '0;
                                    res_byte = CH_N;
                                end
                            end else if (i_in_byte == CH_PLUS) begin
                                if (r_prev_nl) n_phase   = PH_PLUS;
                                else           res_valid = 1'b1;
                            end else begin
                                if (!count_max) n_count = r_count + COUNT_BITS'(1);
                                res_valid = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // output register and skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_done   = r_out_done;
        n_skid_valid = r_skid_valid;
        n_skid_byte  = r_skid_byte;
        n_skid_done  = r_skid_done;
        if (res_valid && r_out_valid && !out_take) begin
            n_skid_valid = 1'b1;
            n_skid_byte  = res_byte;
            n_skid_done  = res_done;
        end else if (res_valid) begin
            n_out_valid = 1'b1;
            n_out_byte  = res_byte;
            n_out_done  = res_done;
        end else if (out_take) begin
            n_out_valid  = r_skid_valid;
            n_out_byte   = r_skid_byte;
            n_out_done   = r_skid_done;
            n_skid_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fastq      <= 1'b0;
            r_phase      <= PH_NORMAL;
            r_prev_nl    <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_fastq <= i_cfg_data;
            r_phase      <= n_phase;
            r_prev_nl    <= n_prev_nl;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_done  <= n_out_done;
        r_skid_byte <= n_skid_byte;
        r_skid_done <= n_skid_done;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_stream_done = r_out_done;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_eoi_to_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_end_of_input) |=> (r_phase == PH_NORMAL))
        else $error("end of input did not return phase to normal");

    a_done_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_stream_done) |-> (o_out_byte == 8'd0))
        else $error("done word carries nonzero byte");

    a_qual_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_QUAL) |-> (r_count != '0))
        else $error("quality phase with zero letter count");
`endif

endmodule
